### src/irf_pkg.sv
// shared types, constants and helpers for the integer radix formatter
`default_nettype none

package irf_pkg;

  // stream and register port widths
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned WIDTH_W     = 7;
  localparam int unsigned CFG_ADDR_W  = 5;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned BITS_PER_CYC = 4;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_RADIX       = 3'd0;
  localparam logic [2:0] REG_UPPER       = 3'd1;
  localparam logic [2:0] REG_SHOW_MIN    = 3'd2;
  localparam logic [2:0] REG_SHOW_PLUS   = 3'd3;
  localparam logic [2:0] REG_FIELD_WIDTH = 3'd4;
  localparam logic [2:0] REG_PAD_BYTE    = 3'd5;

  // radix and width limits
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [WIDTH_W-1:0] MAX_TEXT  = 7'd64;

  // character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER = 8'h61;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;
  localparam logic [RADIX_W-1:0] DEC_LIMIT = 6'd10;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               upper;
    logic               show_minus;
    logic               show_plus;
    logic [WIDTH_W-1:0] field_width;
    logic [CHAR_W-1:0]  pad_byte;
  } cfg_t;

  typedef struct packed {
    logic start;  // load a new dividend
    logic cont;   // divide the held quotient again
  } div_ctl_t;

  typedef struct packed {
    logic               done;
    logic [RADIX_W-1:0] rem;
    logic               q_zero;
  } div_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PREP,
    S_PAD,
    S_SIGN,
    S_DIG
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    if (d < DEC_LIMIT) begin
      digit_char = CH_ZERO + CHAR_W'(d);
    end else begin
      base = upper ? CH_UPPER : CH_LOWER;
      digit_char = base + CHAR_W'(d - DEC_LIMIT);
    end
  endfunction

endpackage

`default_nettype wire

### src/irf_cfg.sv
// configuration register file with apb-style access
`default_nettype none

module irf_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [irf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [irf_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [irf_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output irf_pkg::cfg_t                         cfg
);

  irf_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radix       <= 6'd10;
      cfg_r.upper       <= 1'b0;
      cfg_r.show_minus  <= 1'b1;
      cfg_r.show_plus   <= 1'b0;
      cfg_r.field_width <= '0;
      cfg_r.pad_byte    <= 8'h20;
    end else if (wr_en) begin
      case (idx)
        irf_pkg::REG_RADIX:       cfg_r.radix       <= pwdata[irf_pkg::RADIX_W-1:0];
        irf_pkg::REG_UPPER:       cfg_r.upper       <= pwdata[0];
        irf_pkg::REG_SHOW_MIN:    cfg_r.show_minus  <= pwdata[0];
        irf_pkg::REG_SHOW_PLUS:   cfg_r.show_plus   <= pwdata[0];
        irf_pkg::REG_FIELD_WIDTH: cfg_r.field_width <= pwdata[irf_pkg::WIDTH_W-1:0];
        irf_pkg::REG_PAD_BYTE:    cfg_r.pad_byte    <= pwdata[irf_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      irf_pkg::REG_RADIX:       prdata = irf_pkg::CFG_DATA_W'(cfg_r.radix);
      irf_pkg::REG_UPPER:       prdata = irf_pkg::CFG_DATA_W'(cfg_r.upper);
      irf_pkg::REG_SHOW_MIN:    prdata = irf_pkg::CFG_DATA_W'(cfg_r.show_minus);
      irf_pkg::REG_SHOW_PLUS:   prdata = irf_pkg::CFG_DATA_W'(cfg_r.show_plus);
      irf_pkg::REG_FIELD_WIDTH: prdata = irf_pkg::CFG_DATA_W'(cfg_r.field_width);
      irf_pkg::REG_PAD_BYTE:    prdata = irf_pkg::CFG_DATA_W'(cfg_r.pad_byte);
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### src/irf_div.sv
// iterative divider by a small radix, four quotient bits per cycle
`default_nettype none

module irf_div #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire irf_pkg::div_ctl_t             ctl,
  input  wire logic [DATA_WIDTH-1:0]         dividend,
  input  wire logic [irf_pkg::RADIX_W-1:0]   radix,
  output irf_pkg::div_sts_t                  sts
);

  localparam int unsigned STEP = irf_pkg::BITS_PER_CYC;
  localparam int unsigned DWP  = ((DATA_WIDTH + STEP - 1) / STEP) * STEP;
  localparam int unsigned NCYC = DWP / STEP;
  localparam int unsigned CW   = $clog2(NCYC);
  localparam int unsigned RW   = irf_pkg::RADIX_W;

  logic [DWP-1:0]          q_r, q_nxt;
  logic [RW-1:0]           rem_r, rem_nxt;
  logic [RW-1:0]           radix_r;
  logic [CW-1:0]           cnt_r;
  logic                    run_r;
  logic                    done_r;
  logic [DWP+STEP-1:0]     div_ext;

  assign div_ext = {{(DWP + STEP - DATA_WIDTH){1'b0}}, dividend};

  // restoring division, STEP bits of quotient per cycle
  always_comb begin
    logic [RW:0] t;
    t       = '0;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    for (int i = 0; i < STEP; i++) begin
      t       = {rem_nxt, q_nxt[DWP-1]};
      q_nxt   = {q_nxt[DWP-2:0], 1'b0};
      if (t >= {1'b0, radix_r}) begin
        rem_nxt  = RW'(t - {1'b0, radix_r});
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      q_r     <= div_ext[DWP-1:0];
      rem_r   <= '0;
      radix_r <= radix;
    end else if (ctl.cont) begin
      rem_r <= '0;
    end else if (run_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start || ctl.cont) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NCYC - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts = '{done: done_r, rem: rem_r, q_zero: (q_r == '0)};

endmodule

`default_nettype wire

### src/integer_radix_formatter.sv
// top level: integer to text conversion in a configurable radix
// usage
//   in_*   : one item per number; in_tdata = {value, func}, func in bit 0.
//            the block takes an item only when it is idle (in_tready high).
//   out_*  : the text of that number, one character per item, most
//            significant first; out_tlast marks the final character.
//   cfg_*  : apb-style register port; write only while the block is idle.
// digit generation
//   digits are produced by one shared divider that retires four quotient
//   bits per cycle; each digit is the remainder of one full division of
//   the held quotient by the radix, and numbers are converted one at a time.
//   digits sit in a small stack memory and are read back in reverse order.
// reset
//   synchronous active-low rst_n clears the sequencer, the output valid and
//   restores register defaults (radix 10, minus on, pad is a space).
// stall
//   when out_tready is low the output register holds its character and the
//   sequencer waits; nothing is dropped. a new item is taken as soon as the
//   last character is loaded, even while it still waits at the output.
`default_nettype none

module integer_radix_formatter #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [irf_pkg::IN_TDATA_W-1:0]     in_tdata,   // [0] func, [32:1] value
  // output stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [irf_pkg::CHAR_W-1:0]         out_tdata,  // [7:0] text_byte
  output logic                                    out_tlast,
  // configuration port
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [irf_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [irf_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic      [irf_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                    cfg_pready
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned AW = $clog2(DW);      // digit stack address
  localparam int unsigned NW = $clog2(DW + 1);  // digit count
  localparam int unsigned WW = irf_pkg::WIDTH_W;
  localparam int unsigned CH = irf_pkg::CHAR_W;

  irf_pkg::cfg_t     cfg;
  irf_pkg::div_ctl_t div_ctl;
  irf_pkg::div_sts_t div_sts;

  irf_pkg::state_t   state_r, state_nxt;
  logic [NW-1:0]     nd_r, nd_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [WW-1:0]     pad_r, pad_nxt;
  logic [CH-1:0]     sign_r, sign_nxt;
  logic              neg_r, neg_nxt;

  logic              out_tvalid_r;
  logic [CH-1:0]     out_tdata_r;
  logic              out_tlast_r;
  logic              out_free;
  logic              out_load;
  logic [CH-1:0]     out_byte;
  logic              out_last;

  logic [CH-1:0]     mem [DW];
  logic [CH-1:0]     rd_r;
  logic              wr_en;
  logic [CH-1:0]     wr_data;

  // input decode and magnitude
  logic [DW+irf_pkg::VALUE_W-1:0] val_ext;
  logic [DW-1:0]     val;
  logic              neg_in;
  logic [DW-1:0]     mag;

  // saturated configuration
  logic [irf_pkg::RADIX_W-1:0] radix_eff;
  logic [WW-1:0]     width_eff;
  logic [CH-1:0]     sign_c;
  logic [WW-1:0]     total_c;

  irf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  irf_div #(
    .DATA_WIDTH (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (mag),
    .radix    (radix_eff),
    .sts      (div_sts)
  );

  assign val_ext = {{DW{1'b0}}, in_tdata[irf_pkg::VALUE_W:1]};
  assign val     = val_ext[DW-1:0];
  assign neg_in  = in_tdata[0] & val[DW-1];
  assign mag     = neg_in ? (~val + 1'b1) : val;

  assign radix_eff = (cfg.radix < irf_pkg::RADIX_MIN) ? irf_pkg::RADIX_MIN :
                     (cfg.radix > irf_pkg::RADIX_MAX) ? irf_pkg::RADIX_MAX : cfg.radix;
  assign width_eff = (cfg.field_width > irf_pkg::MAX_TEXT) ? irf_pkg::MAX_TEXT
                                                           : cfg.field_width;

  // minus wins over plus; a negative value with minus off may still get plus
  assign sign_c  = (neg_r && cfg.show_minus) ? irf_pkg::CH_MINUS :
                   cfg.show_plus             ? irf_pkg::CH_PLUS  : irf_pkg::CH_NONE;
  assign total_c = WW'(nd_r) + WW'(sign_c != irf_pkg::CH_NONE);

  assign wr_data  = irf_pkg::digit_char(div_sts.rem, cfg.upper);
  assign out_free = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == irf_pkg::S_IDLE);

  // sequencer: divide, then pads, sign and digits from the top of the stack
  always_comb begin
    state_nxt = state_r;
    nd_nxt    = nd_r;
    idx_nxt   = idx_r;
    pad_nxt   = pad_r;
    sign_nxt  = sign_r;
    neg_nxt   = neg_r;
    div_ctl   = '0;
    wr_en     = 1'b0;
    out_load  = 1'b0;
    out_byte  = '0;
    out_last  = 1'b0;
    case (state_r)
      irf_pkg::S_IDLE: begin
        if (in_tvalid) begin
          div_ctl.start = 1'b1;
          neg_nxt       = neg_in;
          nd_nxt        = '0;
          state_nxt     = irf_pkg::S_DIV;
        end
      end
      irf_pkg::S_DIV: begin
        if (div_sts.done) begin
          wr_en   = 1'b1;
          nd_nxt  = nd_r + 1'b1;
          idx_nxt = nd_r[AW-1:0];
          if (div_sts.q_zero) begin
            state_nxt = irf_pkg::S_PREP;
          end else begin
            div_ctl.cont = 1'b1;
          end
        end
      end
      irf_pkg::S_PREP: begin
        // top digit is read from the stack during this cycle
        sign_nxt = sign_c;
        pad_nxt  = (width_eff > total_c) ? (width_eff - total_c) : '0;
        if (width_eff > total_c) begin
          state_nxt = irf_pkg::S_PAD;
        end else if (sign_c != irf_pkg::CH_NONE) begin
          state_nxt = irf_pkg::S_SIGN;
        end else begin
          state_nxt = irf_pkg::S_DIG;
        end
      end
      irf_pkg::S_PAD: begin
        if (out_free) begin
          out_load = 1'b1;
          out_byte = cfg.pad_byte;
          pad_nxt  = pad_r - 1'b1;
          if (pad_r == WW'(1)) begin
            state_nxt = (sign_r != irf_pkg::CH_NONE) ? irf_pkg::S_SIGN : irf_pkg::S_DIG;
          end
        end
      end
      irf_pkg::S_SIGN: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_byte  = sign_r;
          state_nxt = irf_pkg::S_DIG;
        end
      end
      irf_pkg::S_DIG: begin
        if (out_free) begin
          out_load = 1'b1;
          out_byte = rd_r;
          if (idx_r == '0) begin
            out_last  = 1'b1;
            state_nxt = irf_pkg::S_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: state_nxt = irf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= irf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nd_r   <= nd_nxt;
    idx_r  <= idx_nxt;
    pad_r  <= pad_nxt;
    sign_r <= sign_nxt;
    neg_r  <= neg_nxt;
  end

  // digit stack, read address runs one step ahead so rd_r holds the next digit
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[nd_r[AW-1:0]] <= wr_data;
    end
    rd_r <= mem[idx_nxt];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= out_byte;
      out_tlast_r <= out_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

`default_nettype wire

### test/tb_integer_radix_formatter.sv
// self-checking testbench for the integer radix formatter: stream stimulus, register setup, text check
module tb_integer_radix_formatter;
  timeunit 1ns;
  timeprecision 1ps;

  // run length guard and fixed waits
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 400;   // receiver hold-off in cycles
  localparam int unsigned SETTLE      = 20;    // idle cycles after the last character

  // one expected character of the text
  typedef struct packed {
    logic [irf_pkg::CHAR_W-1:0] text_byte;
    logic                       is_last;
  } text_char_t;

  logic clk;
  logic rst_n;

  logic                           in_tvalid;
  logic                           in_tready;
  logic [irf_pkg::IN_TDATA_W-1:0] in_tdata;    // [0] func, [32:1] value, rest zero

  logic                           out_tvalid;
  logic                           out_tready;
  logic [irf_pkg::CHAR_W-1:0]     out_tdata;   // [7:0] text_byte
  logic                           out_tlast;

  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [irf_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [irf_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [irf_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  // shadow of the register file, as the block should see it
  irf_pkg::cfg_t fmt_cfg;

  // characters still owed by the block, oldest first
  text_char_t text_q[$];

  int unsigned mismatch_count;
  int unsigned cycle_count;

  // stimulus knobs shared with the receiver
  bit idle_on;
  bit hold_req;

  integer_radix_formatter #(
    .DATA_WIDTH(irf_pkg::VALUE_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // text prediction
  // ---------------------------------------------------------------------------

  // builds the full text of one number under the current register shadow
  // and appends it to the queue of owed characters
  function automatic void format_number(input logic func,
                                        input logic [irf_pkg::VALUE_W-1:0] value);
    logic                        neg;
    logic [irf_pkg::VALUE_W-1:0] mag;
    logic [irf_pkg::VALUE_W-1:0] base;
    logic [irf_pkg::VALUE_W-1:0] d;
    logic [irf_pkg::CHAR_W-1:0]  sign_ch;
    logic [irf_pkg::CHAR_W-1:0]  digs[$];   // least significant digit first
    logic [irf_pkg::CHAR_W-1:0]  chars[$];  // text in send order
    int unsigned                 width;
    int unsigned                 total;
    int unsigned                 i;

    // negative only when read as signed; the most negative value keeps its
    // exact magnitude because the negation wraps to 2^(n-1) unsigned
    neg = func && value[irf_pkg::VALUE_W-1];
    mag = neg ? (~value + 1'b1) : value;

    // out-of-range radix and width saturate
    if (fmt_cfg.radix < irf_pkg::RADIX_MIN)
      base = irf_pkg::VALUE_W'(irf_pkg::RADIX_MIN);
    else if (fmt_cfg.radix > irf_pkg::RADIX_MAX)
      base = irf_pkg::VALUE_W'(irf_pkg::RADIX_MAX);
    else
      base = irf_pkg::VALUE_W'(fmt_cfg.radix);
    width = (fmt_cfg.field_width > irf_pkg::MAX_TEXT) ? irf_pkg::MAX_TEXT
                                                      : fmt_cfg.field_width;

    // zero still gives one digit
    do begin
      d = mag % base;
      if (d < irf_pkg::DEC_LIMIT)
        digs.push_back(irf_pkg::CH_ZERO + irf_pkg::CHAR_W'(d));
      else
        digs.push_back((fmt_cfg.upper ? irf_pkg::CH_UPPER : irf_pkg::CH_LOWER) +
                       irf_pkg::CHAR_W'(d - irf_pkg::DEC_LIMIT));
      mag = mag / base;
    end while (mag != 0 && digs.size() < irf_pkg::MAX_TEXT);

    // minus wins when allowed, else plus, also for a negative value with minus off
    if (neg && fmt_cfg.show_minus)
      sign_ch = irf_pkg::CH_MINUS;
    else if (fmt_cfg.show_plus)
      sign_ch = irf_pkg::CH_PLUS;
    else
      sign_ch = irf_pkg::CH_NONE;

    total = digs.size() + ((sign_ch != irf_pkg::CH_NONE) ? 1 : 0);

    // pads go in front of the sign
    for (i = total; i < width; i++)
      chars.push_back(fmt_cfg.pad_byte);
    if (sign_ch != irf_pkg::CH_NONE)
      chars.push_back(sign_ch);
    for (i = digs.size(); i > 0; i--)
      chars.push_back(digs[i-1]);

    for (i = 0; i < chars.size(); i++)
      text_q.push_back('{text_byte: chars[i], is_last: (i == chars.size() - 1)});
  endfunction

  // ---------------------------------------------------------------------------
  // result check: every accepted character against the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_text
    text_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (text_q.size() == 0) begin
        $error("unexpected item: text_byte 0x%02h last %0b", out_tdata, out_tlast);
        mismatch_count++;
      end else begin
        want = text_q.pop_front();
        if (out_tdata !== want.text_byte) begin
          $error("text_byte: expected 0x%02h, got 0x%02h", want.text_byte, out_tdata);
          mismatch_count++;
        end
        if (out_tlast !== want.is_last) begin
          $error("last: expected %0b, got %0b", want.is_last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold so the block fills and pushes back on its input
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared drivers; all called and returning at a falling edge
  // ---------------------------------------------------------------------------

  // one register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [2:0] idx,
                           input logic [irf_pkg::CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    // the block keeps only the low bits of each register
    case (idx)
      irf_pkg::REG_RADIX:       fmt_cfg.radix       = data[irf_pkg::RADIX_W-1:0];
      irf_pkg::REG_UPPER:       fmt_cfg.upper       = data[0];
      irf_pkg::REG_SHOW_MIN:    fmt_cfg.show_minus  = data[0];
      irf_pkg::REG_SHOW_PLUS:   fmt_cfg.show_plus   = data[0];
      irf_pkg::REG_FIELD_WIDTH: fmt_cfg.field_width = data[irf_pkg::WIDTH_W-1:0];
      irf_pkg::REG_PAD_BYTE:    fmt_cfg.pad_byte    = data[irf_pkg::CHAR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // register word with random junk in bits 23:8 above the given low byte
  function automatic logic [irf_pkg::CFG_DATA_W-1:0] with_junk(input logic [7:0] low);
    with_junk = {8'h00, 16'($urandom_range(0, 16'hFFFF)), low};
  endfunction

  // writes all six registers; junk above bit 7 must be dropped by the block
  task automatic apply_format(input logic [7:0] radix, input logic upper, input logic minus,
                              input logic plus, input logic [7:0] width, input logic [7:0] pad);
    write_reg(irf_pkg::REG_RADIX,       with_junk(radix));
    write_reg(irf_pkg::REG_UPPER,       with_junk({7'h00, upper}));
    write_reg(irf_pkg::REG_SHOW_MIN,    with_junk({7'h00, minus}));
    write_reg(irf_pkg::REG_SHOW_PLUS,   with_junk({7'h00, plus}));
    write_reg(irf_pkg::REG_FIELD_WIDTH, with_junk(width));
    write_reg(irf_pkg::REG_PAD_BYTE,    with_junk(pad));
  endtask

  // offers one number and waits for the block to take it; valid stays high
  // on return so back-to-back items need no gap
  task automatic send_number(input logic func, input logic [irf_pkg::VALUE_W-1:0] value);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= irf_pkg::IN_TDATA_W'({value, func});
    do @(posedge clk); while (!in_tready);
    format_number(func, value);
    @(negedge clk);
  endtask

  // stops offering, waits out every owed character and lets the block settle
  task automatic drain_text;
    in_tvalid <= 1'b0;
    while (text_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // value mix: small numbers, extremes, neighbors of the sign boundary, full range
  function automatic logic [irf_pkg::VALUE_W-1:0] pick_value;
    case ($urandom_range(0, 6))
      0:       pick_value = $urandom_range(0, 40);
      1:       pick_value = 32'h8000_0000 + $urandom_range(0, 3);
      2:       pick_value = 32'h0 - $urandom_range(1, 40);
      3:       pick_value = $urandom >> $urandom_range(0, 31);
      4:       pick_value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
      default: pick_value = $urandom;
    endcase
  endfunction

  // random register setting, mostly legal ranges and short widths
  task automatic apply_random_format;
    logic [7:0] radix;
    logic [7:0] width;
    radix = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 63))
                                         : 8'($urandom_range(2, 36));
    case ($urandom_range(0, 5))
      0:       width = 8'd64;
      1:       width = 8'($urandom_range(0, 127));
      default: width = 8'($urandom_range(0, 16));
    endcase
    apply_format(radix, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), width, 8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values: decimal, minus on, no padding
  task automatic test_reset_format;
    send_number(1'b0, 32'h0000_0000);
    send_number(1'b1, 32'h0000_0000);
    send_number(1'b0, 32'hFFFF_FFFF);
    send_number(1'b1, 32'hFFFF_FFFF);
    send_number(1'b1, 32'h8000_0000);
    send_number(1'b1, 32'h7FFF_FFFF);
    send_number(1'b0, 32'h8000_0000);
    send_number(1'b0, 32'd12345);
    drain_text;
  endtask

  // hex, letter case, plus instead of minus, zero padding, saturated radix and width
  task automatic test_directed_formats;
    // upper hex, minus off so a negative value shows '+' and its magnitude
    apply_format(8'd16, 1'b1, 1'b0, 1'b1, 8'd12, 8'h30);
    send_number(1'b1, 32'hFFFF_FFFF);
    send_number(1'b0, 32'hDEAD_BEEF);
    send_number(1'b1, 32'h0000_0000);
    drain_text;
    // top radix with lower case letters, both signs on
    apply_format(8'd36, 1'b0, 1'b1, 1'b1, 8'd0, 8'h2A);
    send_number(1'b1, 32'h8000_0000);
    send_number(1'b1, 32'h7FFF_FFFF);
    send_number(1'b0, 32'hFFFF_FFFF);
    drain_text;
    // radix 0 acts as binary, width 127 acts as 64: longest texts
    apply_format(8'd0, 1'b1, 1'b1, 1'b0, 8'd127, 8'hFF);
    send_number(1'b1, 32'h8000_0000);
    send_number(1'b0, 32'h0000_0000);
    drain_text;
    // radix 63 acts as 36, width exactly 64, pad with code zero
    apply_format(8'd63, 1'b1, 1'b0, 1'b0, 8'd64, 8'h00);
    send_number(1'b1, 32'h0001_2345);
    send_number(1'b0, 32'hFFFF_FFFF);
    drain_text;
    // radix 1 acts as binary
    apply_format(8'd1, 1'b0, 1'b1, 1'b1, 8'd3, 8'h5F);
    send_number(1'b1, 32'hFFFF_FFFE);
    send_number(1'b0, 32'h0000_0005);
    drain_text;
  endtask

  // receiver holds off while numbers keep coming, so the input stalls
  task automatic test_output_stall;
    apply_format(8'd10, 1'b0, 1'b1, 1'b1, 8'd6, 8'h20);
    hold_req = 1'b1;
    repeat (6) send_number(1'($urandom_range(0, 1)), pick_value());
    drain_text;
  endtask

  // random numbers under a series of random settings, idling on both sides
  task automatic test_random_formats;
    repeat (5) begin
      apply_random_format();
      repeat (15) send_number(1'($urandom_range(0, 1)), pick_value());
      drain_text;
    end
  endtask

  // last stretch at full rate on both sides
  task automatic test_full_rate;
    idle_on = 1'b0;
    apply_random_format();
    repeat (15) send_number(1'($urandom_range(0, 1)), pick_value());
    drain_text;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // every input known from time zero
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    idle_on  = 1'b1;
    hold_req = 1'b0;

    // register defaults after reset
    fmt_cfg.radix       = 6'd10;
    fmt_cfg.upper       = 1'b0;
    fmt_cfg.show_minus  = 1'b1;
    fmt_cfg.show_plus   = 1'b0;
    fmt_cfg.field_width = 7'd0;
    fmt_cfg.pad_byte    = 8'h20;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_format();
    test_directed_formats();
    test_output_stall();
    test_random_formats();
    test_full_rate();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
